// ===== rtl/interval_activity_selection_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the activity selection block.
// ---------------------------------------------------------------------------
`ifndef INTERVAL_ACTIVITY_SELECTION_MACROS_SVH
`define INTERVAL_ACTIVITY_SELECTION_MACROS_SVH

// expression must hold at every clock edge out of reset
`define IAS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ias_pkg.sv =====
// ---------------------------------------------------------------------------
// ias_pkg
// Types shared by the activity selection block and its sub-modules.
// ---------------------------------------------------------------------------
package ias_pkg;

  localparam int TIME_W  = 32;
  localparam int COUNT_W = 11;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              last_item;
  } ias_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] selected_count;
    logic               overflow;
  } ias_out_t;

  // one stored interval
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } ias_ivl_t;

  localparam int IVL_W = $bits(ias_ivl_t);

endpackage

// ===== rtl/ias_ram.sv =====
// ---------------------------------------------------------------------------
// ias_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ias_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/interval_activity_selection.sv =====
// ---------------------------------------------------------------------------
// interval_activity_selection
// Greedy activity selection, earliest finish first, over a stored interval set.
// ---------------------------------------------------------------------------
// Intervals are loaded one per transfer and kept in a RAM ordered by end time
// (stable for equal ends) by an insertion sort that moves one entry at a time,
// in a read state and a compare-and-write state, through a single compare unit
// and the RAM's one read and one write port. Once the store holds CAPACITY
// entries further intervals are dropped and flag overflow. The transfer marked
// last_item then starts a scan of the n stored entries at one RAM read per cycle
// through the same comparator, after which the count is offered on the result
// channel. The input is stalled while an interval is being sorted in, the set is
// being scanned or its count waits in S_DONE for the result register to free;
// a new set may be loaded while the previous result still waits.
// ---------------------------------------------------------------------------
`include "interval_activity_selection_macros.svh"

module interval_activity_selection import ias_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ias_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ias_out_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_SCAN,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     taken_r, taken_nxt;
  logic              ovf_r, ovf_nxt;
  logic              last_r, last_nxt;
  logic              pend_r, pend_nxt;
  logic [TIME_W-1:0] limit_r, limit_nxt;
  ias_ivl_t          new_r, new_nxt;
  logic              out_valid_r, out_valid_nxt;
  ias_out_t          out_data_r, out_data_nxt;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  ias_ivl_t          wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [IVL_W-1:0]  rd_raw;
  ias_ivl_t          rd_ivl;

  logic              accept;
  logic              scanning;
  logic [TIME_W-1:0] cmp_a, cmp_b;
  logic              cmp_gt;
  logic [CW-1:0]     pos_dec;
  logic [31:0]       taken_ext;

  ias_ram #(
    .WIDTH (IVL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_ivl   = ias_ivl_t'(rd_raw);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign pos_dec  = pos_r - ONE_C;

  // the one comparator: stored end vs new end while sorting,
  // stored start vs current limit while scanning
  assign scanning = (state_r == S_SCAN);
  assign cmp_a    = scanning ? rd_ivl.start_time : rd_ivl.end_time;
  assign cmp_b    = scanning ? limit_r : new_r.end_time;
  assign cmp_gt   = (cmp_a > cmp_b);

  assign taken_ext = 32'(taken_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    taken_nxt     = taken_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    pend_nxt      = pend_r;
    limit_nxt     = limit_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r[AW-1:0];
    wr_data       = new_r;
    rd_en         = 1'b0;
    rd_addr       = pos_dec[AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_nxt.start_time = in_data.start_time;
          new_nxt.end_time   = in_data.end_time;
          last_nxt           = in_data.last_item;
          pos_nxt            = count_r;
          if (count_r < CAP_C) begin
            state_nxt = S_INS_RD;
          end else begin
            ovf_nxt = 1'b1;
            if (in_data.last_item) begin
              state_nxt = S_SCAN;
              pos_nxt   = '0;
              pend_nxt  = 1'b0;
            end
          end
        end
      end

      S_INS_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          count_nxt = count_r + ONE_C;
          state_nxt = last_r ? S_SCAN : S_IDLE;
          pos_nxt   = '0;
          pend_nxt  = 1'b0;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        wr_en = 1'b1;
        if (cmp_gt) begin
          // stored end is later: move it up one place
          wr_data   = rd_ivl;
          pos_nxt   = pos_dec;
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + ONE_C;
          state_nxt = last_r ? S_SCAN : S_IDLE;
          pos_nxt   = '0;
          pend_nxt  = 1'b0;
        end
      end

      S_SCAN: begin
        // pos_r walks the read address, data follows in the next cycle
        rd_addr = pos_r[AW-1:0];
        if (pos_r != count_r) begin
          rd_en    = 1'b1;
          pos_nxt  = pos_r + ONE_C;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
        if (pend_r) begin
          if (taken_r == '0 || cmp_gt) begin
            taken_nxt = taken_r + ONE_C;
            limit_nxt = rd_ivl.end_time;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.selected_count = taken_ext[COUNT_W-1:0];
          out_data_nxt.overflow       = ovf_r;
          count_nxt                   = '0;
          ovf_nxt                     = 1'b0;
          taken_nxt                   = '0;
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      taken_r     <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      taken_r     <= taken_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    limit_r    <= limit_nxt;
    new_r      <= new_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a dropped interval without last_item leaves the input open
  `IAS_ASSERT_NEXT(a_busy_after_load, accept && count_r != CAP_C, in_stall, "no stall after load")
  `IAS_ASSERT_ALWAYS(a_count_in_range, count_r <= CAP_C, "entry count above capacity")
  `IAS_ASSERT_ALWAYS(a_taken_bounded, taken_r <= count_r, "selected count above stored count")
  `IAS_ASSERT_NEXT(a_out_from_done, !out_valid && state_r != S_DONE, !out_valid, "stray result")

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Testbench for interval_activity_selection. Intervals are loaded in sets and
// a behavioural tracker re-orders them by end time and counts the greedy
// selection for each set; count and overflow are checked against the block.
// The run covers edge values, equal ends, strict start comparison, a full
// store with dropped intervals, and random sets under varied idling.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ias_pkg::*;

  localparam int STORE_DEPTH  = 1024;
  localparam int LOAD_TARGET  = 1650;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_TIME  = 64;

  // tracks the interval set being loaded and the counts still owed
  class selection_tracker;
    ias_ivl_t held[$];
    bit       dropped;
    ias_out_t pending_counts[$];
    int       fails;

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      fails++;
    endtask

    function int greedy_count();
      int               taken;
      logic [TIME_W-1:0] limit;
      if (held.size() == 0) return 0;
      taken = 1;
      limit = held[0].end_time;
      for (int k = 1; k < held.size(); k++) begin
        if (held[k].start_time > limit) begin
          limit = held[k].end_time;
          taken++;
        end
      end
      return taken;
    endfunction

    function void note_interval(ias_in_t item);
      ias_ivl_t ivl;
      ias_out_t res;
      int       pos;
      int       taken;
      if (held.size() < STORE_DEPTH) begin
        ivl.start_time = item.start_time;
        ivl.end_time   = item.end_time;
        pos = held.size();
        // stable: goes after every entry whose end is not above its own
        while (pos > 0 && held[pos-1].end_time > item.end_time) pos--;
        if (pos == held.size()) held.push_back(ivl);
        else held.insert(pos, ivl);
      end else begin
        dropped = 1'b1;
      end
      if (item.last_item) begin
        taken = greedy_count();
        res.selected_count = taken[COUNT_W-1:0];
        res.overflow       = dropped;
        pending_counts.push_back(res);
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    task check_count(ias_out_t got);
      ias_out_t want;
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("result count=%0d ovf=%0b with no set outstanding",
                                  got.selected_count, got.overflow));
      end else begin
        want = pending_counts.pop_front();
        if (got.selected_count !== want.selected_count)
          report_mismatch($sformatf("selected_count %0d, expected %0d",
                                    got.selected_count, want.selected_count));
        if (got.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %0b, expected %0b",
                                    got.overflow, want.overflow));
      end
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ias_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ias_out_t out_data;

  selection_tracker tracker = new;
  ias_in_t          load_list[$];
  int               send_idle_pct;
  int               recv_stall_pct;
  int               cycle_count = 0;

  interval_activity_selection #(.CAPACITY(STORE_DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function void add_interval(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e, bit last);
    ias_in_t item;
    item.start_time = s;
    item.end_time   = e;
    item.last_item  = last;
    load_list.push_back(item);
  endfunction

  function void add_random_set();
    int                n;
    int                mode;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    n    = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 40);
    mode = $urandom_range(3);
    for (int k = 0; k < n; k++) begin
      case (mode)
        0: begin
          // short, mostly well-formed intervals on a narrow time line
          s = $urandom_range(60);
          e = s + $urandom_range(12);
          if ($urandom_range(9) == 0) e = $urandom_range(60);
        end
        1: begin
          s = $urandom;
          e = $urandom;
        end
        2: begin
          s = 32'hFFFF_FF80 + $urandom_range(127);
          e = 32'hFFFF_FF80 + $urandom_range(127);
        end
        default: begin
          // few distinct ends, so ties are common
          s = $urandom_range(40);
          e = 10 * $urandom_range(1, 4);
        end
      endcase
      add_interval(s, e, k == n - 1);
    end
  endfunction

  task send_interval(ias_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    tracker.note_interval(item);
    @(negedge clk);
  endtask

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_count(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int third;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_idle_pct  = 24;
    recv_stall_pct = 72;

    // directed sets
    add_interval(32'h0, 32'h0, 1'b1);
    add_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_interval(32'h0, 32'hFFFF_FFFF, 1'b0);
    add_interval(32'hFFFF_FFFF, 32'h0, 1'b0);
    add_interval(32'h0, 32'h0, 1'b1);
    // equal ends keep arrival order: 2 one way, 3 the other
    add_interval(20, 10, 1'b0);
    add_interval(0, 10, 1'b0);
    add_interval(12, 15, 1'b1);
    add_interval(0, 10, 1'b0);
    add_interval(20, 10, 1'b0);
    add_interval(12, 15, 1'b1);
    // start equal to the last taken end is not taken
    add_interval(0, 5, 1'b0);
    add_interval(5, 9, 1'b0);
    add_interval(6, 9, 1'b1);
    // arrival in falling end order, each one sorted past all held
    add_interval(30, 35, 1'b0);
    add_interval(20, 25, 1'b0);
    add_interval(10, 15, 1'b0);
    add_interval(0, 5, 1'b1);
    // start after end
    add_interval(50, 40, 1'b0);
    add_interval(45, 60, 1'b1);

    while (load_list.size() < 320) add_random_set();
    // full store of disjoint intervals, then drops, the last one ending the set
    for (int k = 0; k < STORE_DEPTH; k++) add_interval(4 * k + 1, 4 * k + 2, 1'b0);
    add_interval($urandom, $urandom, 1'b0);
    add_interval($urandom, $urandom, 1'b0);
    add_interval(32'h0, 32'h0, 1'b1);
    while (load_list.size() < LOAD_TARGET) add_random_set();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    third = load_list.size() / 3;
    for (int i = 0; i < load_list.size(); i++) begin
      if (i == third) begin
        send_idle_pct  = 72;
        recv_stall_pct = 24;
      end else if (i == 2 * third) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      send_interval(load_list[i]);
    end
    in_valid <= 1'b0;

    while (tracker.pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);

    if (tracker.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
